FILE: rtl/core/unique_key_pair_set_assert.svh
// Assertion macros shared by the unique key pair set checkers.
`ifndef UNIQUE_KEY_PAIR_SET_ASSERT_SVH
`define UNIQUE_KEY_PAIR_SET_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define UKPS_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("ukps assertion failed");

// Next-cycle implication, disabled while dis is high.
`define UKPS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("ukps assertion failed");

`endif

FILE: rtl/core/ukps_pkg.sv
// Shared types and constants for the unique key pair set.
package ukps_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 2;
  localparam int AREA_W   = 10;
  localparam int NUM_W    = 24;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  // Item queues on both sides of the engine.
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
  localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(Q_DEPTH);
  localparam logic [QPTR_W-1:0] Q_LAST = QPTR_W'(Q_DEPTH - 1);

  // Largest count the result port can show.
  localparam logic [ENTRY_W-1:0] COUNT_MAX =
    ENTRY_W'((DEPTH > (1 << ENTRY_W) - 1) ? (1 << ENTRY_W) - 1 : DEPTH);

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Classified request; an unused opcode has no kind bit set.
  typedef struct packed {
    logic              is_add;
    logic              is_remove;
    logic              is_query;
    logic [AREA_W-1:0] area;
    logic [NUM_W-1:0]  number;
  } req_t;

  typedef struct packed {
    logic               success;
    status_t            status;
    logic [ENTRY_W-1:0] entry_count;
  } res_t;

  // Engine to result queue.
  typedef struct packed {
    logic push;
    res_t res;
  } res_wr_t;

endpackage

FILE: rtl/core/ukps_front.sv
// Front end: request queue with opcode classification.
module ukps_front
  import ukps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation,
  input  logic [AREA_W-1:0] area_code,
  input  logic [NUM_W-1:0]  phone_number,
  output logic              req_valid,
  output req_t              req,
  input  logic              req_take
);

  req_t              req_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  req_t              req_in;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == Q_FULL);
  assign req_valid = (count != '0);
  assign req       = req_mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_comb begin
    req_in.is_add    = (operation == OP_ADD);
    req_in.is_remove = (operation == OP_REMOVE);
    req_in.is_query  = (operation == OP_QUERY);
    req_in.area      = area_code;
    req_in.number    = phone_number;
  end

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_next = count + QCNT_W'(1);
      2'b01:   count_next = count - QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_LAST) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_LAST) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      req_mem[wr_ptr] <= req_in;
    end
  end

endmodule

FILE: rtl/core/ukps_back.sv
// Back end: slot array with parallel match, lookup then commit.
module ukps_back
  import ukps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  req_t    req,
  output logic    req_take,
  input  logic    res_space,
  output res_wr_t res_wr
);

  typedef enum logic [1:0] {
    S_LOOKUP = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  valid_next;
  logic [AREA_W-1:0] slot_area [DEPTH];
  logic [NUM_W-1:0]  slot_num  [DEPTH];
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  total_next;

  logic [DEPTH-1:0]  pair_match;
  logic [DEPTH-1:0]  area_match;
  logic [DEPTH-1:0]  free_onehot;

  // lookup results held for the commit cycle
  req_t              cur;
  logic [DEPTH-1:0]  pair_vec;
  logic [DEPTH-1:0]  free_vec;
  logic              pair_hit;
  logic              area_hit;
  logic              table_full;

  logic              commit_add;
  res_t              res;

  assign req_take = (state == S_LOOKUP) && req_valid && res_space;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      area_match[i] = valid[i] && (slot_area[i] == req.area);
      pair_match[i] = area_match[i] && (slot_num[i] == req.number);
    end
  end

  // lowest clear bit of the valid vector
  assign free_onehot = ~valid & (valid + DEPTH'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOOKUP: if (req_take) state_next = S_COMMIT;
      S_COMMIT: state_next = S_LOOKUP;
      default:  state_next = S_LOOKUP;
    endcase
  end

  always_comb begin
    valid_next      = valid;
    total_next      = total;
    commit_add      = 1'b0;
    res.success     = 1'b0;
    res.status      = ST_NOT_FOUND;
    priority if (cur.is_add) begin
      priority if (pair_hit) begin
        res.status = ST_DUP;
      end else if (table_full) begin
        res.status = ST_FULL;
      end else begin
        commit_add  = (state == S_COMMIT);
        valid_next  = valid | free_vec;
        total_next  = total + CNT_W'(1);
        res.success = 1'b1;
        res.status  = ST_DONE;
      end
    end else if (cur.is_remove) begin
      if (pair_hit) begin
        valid_next  = valid & ~pair_vec;
        total_next  = total - CNT_W'(1);
        res.success = 1'b1;
        res.status  = ST_DONE;
      end
    end else if (cur.is_query) begin
      if (area_hit) begin
        res.success = 1'b1;
        res.status  = ST_DONE;
      end
    end else begin
      res.status = ST_NOT_FOUND;
    end
    res.entry_count = ENTRY_W'(total_next);
  end

  assign res_wr.push = (state == S_COMMIT);
  assign res_wr.res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOOKUP;
      valid <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      if (state == S_COMMIT) begin
        valid <= valid_next;
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur        <= req;
      pair_vec   <= pair_match;
      free_vec   <= free_onehot;
      pair_hit   <= |pair_match;
      area_hit   <= |area_match;
      table_full <= &valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (commit_add && free_vec[i]) begin
        slot_area[i] <= cur.area;
        slot_num[i]  <= cur.number;
      end
    end
  end

endmodule

FILE: rtl/core/ukps_resq.sv
// Result queue feeding the pop side.
module ukps_resq
  import ukps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  res_wr_t             res_wr,
  output logic                res_space,
  output logic                empty,
  input  logic                pop,
  output logic                success,
  output logic [STATUS_W-1:0] status,
  output logic [ENTRY_W-1:0]  entry_count
);

  res_t              res_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_pop;
  res_t              head;

  assign res_space   = (count != Q_FULL);
  assign empty       = (count == '0);
  assign do_pop      = pop && !empty;
  assign head        = res_mem[rd_ptr];
  assign success     = head.success;
  assign status      = head.status;
  assign entry_count = head.entry_count;

  // the engine only starts an item when there is room, so push never overflows
  always_comb begin
    unique case ({res_wr.push, do_pop})
      2'b10:   count_next = count + QCNT_W'(1);
      2'b01:   count_next = count - QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (res_wr.push) begin
        wr_ptr <= (wr_ptr == Q_LAST) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_LAST) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr.push) begin
      res_mem[wr_ptr] <= res_wr.res;
    end
  end

endmodule

FILE: rtl/core/unique_key_pair_set.sv
// Top level of the unique key pair set.
// A set of up to DEPTH (16) distinct (area code, phone number) pairs held in
// flip-flop slots with one comparator per slot. Each item is an add, a remove
// or an area-code query, and returns exactly one result item: success flag,
// status (done, duplicate, not found, table full) and the entry count after
// the item. Opcode three changes nothing and reports not found. Items go in
// through a two-entry request queue (push/full) and come out of a two-entry
// result queue (pop/empty), so either side may stall on its own. The engine
// works on one item at a time: in the lookup state it compares the request
// against all slots in parallel and registers the hit vectors, then the commit
// state commits the update and writes the result. Adds fill the lowest free
// slot; a duplicate add to a full table reports duplicate. Reset clears the
// valid bits at once; the slot contents are not reset.
module unique_key_pair_set
  import ukps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [OP_W-1:0]     operation,
  input  logic [AREA_W-1:0]   area_code,
  input  logic [NUM_W-1:0]    phone_number,
  output logic                empty,
  input  logic                pop,
  output logic                success,
  output logic [STATUS_W-1:0] status,
  output logic [ENTRY_W-1:0]  entry_count
);

  logic    req_valid;
  req_t    req;
  logic    req_take;
  logic    res_space;
  res_wr_t res_wr;

  // request side: buffer and classify
  ukps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .area_code    (area_code),
    .phone_number (phone_number),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take)
  );

  // slot array and lookup/commit engine
  ukps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .res_space (res_space),
    .res_wr    (res_wr)
  );

  // result side
  ukps_resq u_resq (
    .clk         (clk),
    .rst         (rst),
    .res_wr      (res_wr),
    .res_space   (res_space),
    .empty       (empty),
    .pop         (pop),
    .success     (success),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

FILE: rtl/core/ukps_checker.sv
// Port-level checker for the unique key pair set, bound to the top level.
`include "unique_key_pair_set_assert.svh"

module ukps_checker
  import ukps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic                success,
  input logic [STATUS_W-1:0] status,
  input logic [ENTRY_W-1:0]  entry_count
);

  // success and done status always travel together
  `UKPS_ASSERT_IMPLY(a_success_done, clk, rst, !empty, success == (status == ST_DONE))

  // shown count never exceeds the table size
  `UKPS_ASSERT_IMPLY(a_count_bound, clk, rst, !empty, entry_count <= COUNT_MAX)

  // the result queue comes out of reset empty and the request queue not full
  `UKPS_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, empty && !full)

  // a waiting result holds until taken
  `UKPS_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(entry_count) && $stable(status))

endmodule

bind unique_key_pair_set ukps_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .success     (success),
  .status      (status),
  .entry_count (entry_count)
);
